/* design/tlg_pkg.sv */
// ----------------------------------------------------------------------------
// tlg_pkg: threshold life generation shared definitions
// Grid limits, register codes, result slot codes and the neighbor rule.
// ----------------------------------------------------------------------------
package tlg_pkg;

    // grid limits
    localparam int MAX_COLS = 32;
    localparam int MAX_ROWS = 1024;
    localparam int MIN_DIM  = 2;

    // field and counter widths
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int WIDTH_W     = 6;
    localparam int HEIGHT_W    = 11;
    localparam int RULE_W      = 4;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 11;
    localparam int NUM_SLOTS   = 4;

    // register reset values
    localparam logic [WIDTH_W-1:0]  RESET_GRID_WIDTH  = WIDTH_W'(32);
    localparam logic [HEIGHT_W-1:0] RESET_GRID_HEIGHT = HEIGHT_W'(20);
    localparam logic [RULE_W-1:0]   RESET_BIRTH_LOWER = RULE_W'(0);
    localparam logic [RULE_W-1:0]   RESET_UPPER_LIMIT = RULE_W'(8);

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_WIDTH  = CFG_INDEX_W'(0),
        REG_GRID_HEIGHT = CFG_INDEX_W'(1),
        REG_BIRTH_LOWER = CFG_INDEX_W'(2),
        REG_UPPER_LIMIT = CFG_INDEX_W'(3)
    } cfg_reg_t;

    // result slots of one input word, in emission order
    //   CENTER: middle of the window (or last cell of the previous row)
    //   BELOW : last-row cell under CENTER
    //   RIGHT : right column, middle row (final cell of the row above)
    //   CORNER: right column, bottom row (final cell of the generation)
    typedef enum logic [1:0] {
        SLOT_CENTER = 2'd0,
        SLOT_BELOW  = 2'd1,
        SLOT_RIGHT  = 2'd2,
        SLOT_CORNER = 2'd3
    } slot_t;

    // one input word's pending results and its window geometry
    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic                 wrap;     // column 0: result is previous row's last cell
        logic                 top_ok;   // window top row lies inside the grid
        logic                 left_ok;  // window left column lies inside the grid
        logic [NUM_SLOTS-1:0] pend;
    } job_t;

    // Next state of the cell at (cr, cc) of a 4x4 grid, row-major, index {row, col}.
    // Returns {next, current}.
    function automatic logic [1:0] life_eval(
        input logic [15:0]       grid,
        input logic [1:0]        cr,
        input logic [1:0]        cc,
        input logic [RULE_W-1:0] lower,
        input logic [RULE_W-1:0] upper
    );
        logic [3:0] count;
        logic [1:0] rr;
        logic [1:0] cx;
        logic       cur;
        logic       nxt;
        count = '0;
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                rr = 2'(int'(cr) + dr - 1);
                cx = 2'(int'(cc) + dc - 1);
                if (!(dr == 1 && dc == 1))
                begin
                    count = count + 4'(grid[{rr, cx}]);
                end
            end
        end
        cur = grid[{cr, cc}];
        if (cur)
        begin
            nxt = (count < upper);
        end
        else
        begin
            nxt = (lower < count) && (count < upper);
        end
        return {nxt, cur};
    endfunction

endpackage

/* design/threshold_life_generation_core.sv */
// ----------------------------------------------------------------------------
// threshold_life_generation_core
// One generation of a life-like automaton over a raster cell stream, with a
// two-row line buffer, a 3x3 window and a registered result port.
// ----------------------------------------------------------------------------
// Cells enter in raster order, one per clock unless in_stall is high, and each result
// word names a cell and gives its next state; results come one row and one cell
// behind the input. Every input word leaves a small job on the current window, and
// the single result register drains that job one word per clock while out_stall is
// low. Rows before the last give at most one result per cell, so the input runs at
// one cell per clock there while the output does not stall; in the last row each
// cell but the first yields two results and the final cell four, so the input
// stalls there. Geometry and rule registers are sampled at the first cell of each
// generation; width saturates to 2..32, height to 2..1024.
// ----------------------------------------------------------------------------
module threshold_life_generation_core
    import tlg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // cell input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cell_alive,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [ROW_W-1:0]       row_index,
    output logic [COL_W-1:0]       col_index,
    output logic                   next_alive,
    output logic                   cell_changed,
    output logic                   any_changed,
    output logic                   generation_done
);

    // configuration registers
    logic [WIDTH_W-1:0]  grid_width_reg;
    logic [HEIGHT_W-1:0] grid_height_reg;
    logic [RULE_W-1:0]   birth_lower_reg;
    logic [RULE_W-1:0]   upper_limit_reg;

    // values latched for the running generation
    logic [WIDTH_W-1:0]  gen_w_reg;
    logic [HEIGHT_W-1:0] gen_h_reg;
    logic [RULE_W-1:0]   gen_lo_reg;
    logic [RULE_W-1:0]   gen_up_reg;
    logic [WIDTH_W-1:0]  sat_w;
    logic [HEIGHT_W-1:0] sat_h;

    // raster position of the next input word
    logic [ROW_W-1:0]    in_row_reg;
    logic [COL_W-1:0]    in_col_reg;
    logic [ROW_W-1:0]    in_row_next;
    logic [COL_W-1:0]    in_col_next;

    // line buffer: bit 0 is the row above, bit 1 two rows above
    logic [1:0]          lb_reg [MAX_COLS];
    logic [1:0]          lb_rd;

    // window columns: 0 left, 1 mid, 2 right; bit 0 top, 1 mid, 2 bottom
    logic [2:0]          win_reg [3];

    logic                job_busy;
    job_t                job_reg;
    job_t                job_next;
    job_t                job_new;

    logic                change_seen_reg;
    logic                change_seen_next;

    logic                out_valid_reg;
    logic [ROW_W-1:0]    row_index_reg;
    logic [COL_W-1:0]    col_index_reg;
    logic                next_alive_reg;
    logic                cell_changed_reg;
    logic                any_changed_reg;
    logic                generation_done_reg;

    logic                in_accept;
    logic                out_free;
    logic                emit;
    slot_t               slot;
    logic [NUM_SLOTS-1:0] slot_sel;
    logic [NUM_SLOTS-1:0] pend_after;

    logic                first_cell;
    logic                last_row;
    logic                col_last;
    logic                last_cell;
    logic                col_zero;

    logic [15:0]         grid;
    logic [2:0]          row_ok;
    logic [2:0]          col_ok;
    logic [1:0]          cr;
    logic [1:0]          cc;
    logic [ROW_W-1:0]    res_row;
    logic [COL_W-1:0]    res_col;
    logic [1:0]          eval;
    logic                res_changed;
    logic                seen_now;

    // configuration port always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RESET_GRID_WIDTH;
            grid_height_reg <= RESET_GRID_HEIGHT;
            birth_lower_reg <= RESET_BIRTH_LOWER;
            upper_limit_reg <= RESET_UPPER_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_BIRTH_LOWER: birth_lower_reg <= cfg_data[RULE_W-1:0];
                REG_UPPER_LIMIT: upper_limit_reg <= cfg_data[RULE_W-1:0];
                default:         ;
            endcase
        end
    end

    // geometry clamp
    always_comb
    begin
        if (grid_width_reg < WIDTH_W'(MIN_DIM))
            sat_w = WIDTH_W'(MIN_DIM);
        else if (grid_width_reg > WIDTH_W'(MAX_COLS))
            sat_w = WIDTH_W'(MAX_COLS);
        else
            sat_w = grid_width_reg;

        if (grid_height_reg < HEIGHT_W'(MIN_DIM))
            sat_h = HEIGHT_W'(MIN_DIM);
        else if (grid_height_reg > HEIGHT_W'(MAX_ROWS))
            sat_h = HEIGHT_W'(MAX_ROWS);
        else
            sat_h = grid_height_reg;
    end

    // handshake: stall while the current job still has words after this cycle
    assign out_free   = !out_valid_reg || !out_stall;
    assign job_busy   = (job_reg.pend != '0);
    assign emit       = job_busy && out_free;

    always_comb
    begin
        if (job_reg.pend[SLOT_CENTER])
            slot = SLOT_CENTER;
        else if (job_reg.pend[SLOT_BELOW])
            slot = SLOT_BELOW;
        else if (job_reg.pend[SLOT_RIGHT])
            slot = SLOT_RIGHT;
        else
            slot = SLOT_CORNER;
    end

    assign slot_sel   = NUM_SLOTS'(1) << slot;
    assign pend_after = job_reg.pend & ~(emit ? slot_sel : '0);
    assign in_stall   = (pend_after != '0);
    assign in_accept  = in_valid && !in_stall;

    // raster position decode
    assign first_cell = (in_row_reg == '0) && (in_col_reg == '0);
    assign col_zero   = (in_col_reg == '0);
    assign last_row   = ({1'b0, in_row_reg} == gen_h_reg - HEIGHT_W'(1));
    assign col_last   = ({1'b0, in_col_reg} == gen_w_reg - WIDTH_W'(1));
    assign last_cell  = last_row && col_last;

    always_comb
    begin
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        if (last_cell)
        begin
            in_row_next = '0;
            in_col_next = '0;
        end
        else if (col_last)
        begin
            in_row_next = in_row_reg + ROW_W'(1);
            in_col_next = '0;
        end
        else
        begin
            in_col_next = in_col_reg + COL_W'(1);
        end
    end

    // job left by the accepted word
    always_comb
    begin
        job_new.row     = in_row_reg;
        job_new.col     = in_col_reg;
        job_new.wrap    = col_zero;
        job_new.top_ok  = col_zero ? (in_row_reg >= ROW_W'(3)) : (in_row_reg >= ROW_W'(2));
        job_new.left_ok = col_zero || (in_col_reg >= COL_W'(2));
        job_new.pend[SLOT_CENTER] = col_zero ? (in_row_reg >= ROW_W'(2))
                                             : (in_row_reg != '0);
        job_new.pend[SLOT_BELOW]  = last_row && !col_zero;
        job_new.pend[SLOT_RIGHT]  = last_cell;
        job_new.pend[SLOT_CORNER] = last_cell;

        job_next      = job_reg;
        job_next.pend = pend_after;
        if (in_accept)
            job_next = job_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
            job_reg    <= '0;
            gen_w_reg  <= RESET_GRID_WIDTH;
            gen_h_reg  <= RESET_GRID_HEIGHT;
            gen_lo_reg <= RESET_BIRTH_LOWER;
            gen_up_reg <= RESET_UPPER_LIMIT;
        end
        else
        begin
            job_reg <= job_next;
            if (in_accept)
            begin
                in_row_reg <= in_row_next;
                in_col_reg <= in_col_next;
                if (first_cell)
                begin
                    gen_w_reg  <= sat_w;
                    gen_h_reg  <= sat_h;
                    gen_lo_reg <= birth_lower_reg;
                    gen_up_reg <= upper_limit_reg;
                end
            end
        end
    end

    // line buffer and window shift
    assign lb_rd = lb_reg[in_col_reg];

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            lb_reg[in_col_reg] <= {lb_rd[0], cell_alive};
            win_reg[0]         <= win_reg[1];
            win_reg[1]         <= win_reg[2];
            win_reg[2]         <= {cell_alive, lb_rd[0], lb_rd[1]};
        end
    end

    // masked 4x4 grid: bottom row and right column beyond the window are dead
    assign row_ok = {1'b1, 1'b1, job_reg.top_ok};
    assign col_ok = {!job_reg.wrap, 1'b1, job_reg.left_ok};

    always_comb
    begin
        grid = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                grid[i * 4 + j] = win_reg[j][i] & row_ok[i] & col_ok[j];
            end
        end
    end

    // result position and window center for the selected slot
    always_comb
    begin
        unique case (slot)
            SLOT_CENTER:
            begin
                cr = 2'd1;
                cc = 2'd1;
                if (job_reg.wrap)
                begin
                    res_row = job_reg.row - ROW_W'(2);
                    res_col = COL_W'(gen_w_reg - WIDTH_W'(1));
                end
                else
                begin
                    res_row = job_reg.row - ROW_W'(1);
                    res_col = job_reg.col - COL_W'(1);
                end
            end
            SLOT_BELOW:
            begin
                cr      = 2'd2;
                cc      = 2'd1;
                res_row = job_reg.row;
                res_col = job_reg.col - COL_W'(1);
            end
            SLOT_RIGHT:
            begin
                cr      = 2'd1;
                cc      = 2'd2;
                res_row = job_reg.row - ROW_W'(1);
                res_col = job_reg.col;
            end
            default:
            begin
                cr      = 2'd2;
                cc      = 2'd2;
                res_row = job_reg.row;
                res_col = job_reg.col;
            end
        endcase
    end

    assign eval        = life_eval(grid, cr, cc, gen_lo_reg, gen_up_reg);
    assign res_changed = eval[1] ^ eval[0];
    assign seen_now    = change_seen_reg | res_changed;

    // change flag clears after the final word of the generation
    always_comb
    begin
        change_seen_next = change_seen_reg;
        if (emit)
            change_seen_next = (slot == SLOT_CORNER) ? 1'b0 : seen_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            change_seen_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            change_seen_reg <= change_seen_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            row_index_reg       <= res_row;
            col_index_reg       <= res_col;
            next_alive_reg      <= eval[1];
            cell_changed_reg    <= res_changed;
            any_changed_reg     <= seen_now;
            generation_done_reg <= (slot == SLOT_CORNER);
        end
    end

    assign out_valid       = out_valid_reg;
    assign row_index       = row_index_reg;
    assign col_index       = col_index_reg;
    assign next_alive      = next_alive_reg;
    assign cell_changed    = cell_changed_reg;
    assign any_changed     = any_changed_reg;
    assign generation_done = generation_done_reg;

    // input only waits on a job that still has words to deliver
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> job_busy)
        else $error("input stalled with no pending result");

    // extra result slots only occur in the last row
    assert property (@(posedge clk) disable iff (!rst_n)
        (job_reg.pend[NUM_SLOTS-1:1] != '0) |->
            ({1'b0, job_reg.row} == gen_h_reg - HEIGHT_W'(1)))
        else $error("last-row result pending outside the last row");

    // change flag restarts after the generation's final word
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && slot == SLOT_CORNER) |=> !change_seen_reg)
        else $error("change flag not cleared at end of generation");

endmodule

/* tb/tb_threshold_life_generation_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_threshold_life_generation_core
// Self-checking bench for the life-like generation core. It streams cell
// grids in raster order and checks every next-state word against its own
// three-row model of the grid or, in the directed table, hand-typed words.
// It covers small directed grids, saturated geometry, rule values above eight,
// a register write in the middle of a generation, and random grids with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_threshold_life_generation_core;
    import tlg_pkg::*;

    localparam int SETTLE_CYCLES = 16;     // quiet time before a register write
    localparam int HOLD_CYCLES   = 200;    // long output hold-off
    localparam int MODE_CELLS    = 6;      // random cells per idling mode
    localparam logic [CFG_INDEX_W-1:0] UNUSED_REG_INDEX = CFG_INDEX_W'(13);

    // one result word as the bench sees it
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             nxt;
        logic             chg;
        logic             seen;
        logic             last;
    } life_word_t;

    // one row of the directed stimulus table
    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic                   alive;
        logic [2:0]             typed_count;   // words typed in by hand, 0 = predict
    } stim_row_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_stall;
    logic                   cell_alive = 1'b0;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   out_valid;
    logic                   out_stall  = 1'b0;
    logic [ROW_W-1:0]       row_index;
    logic [COL_W-1:0]       col_index;
    logic                   next_alive;
    logic                   cell_changed;
    logic                   any_changed;
    logic                   generation_done;

    // bench bookkeeping
    int send_idle_pct = 25;
    int recv_idle_pct = 80;
    int error_count   = 0;
    int words_checked = 0;
    int gens_checked  = 0;
    int cells_sent    = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    life_word_t pending_states[$];   // next states still to come out of the core
    life_word_t step_states[$];      // next states freed by the latest cell
    life_word_t typed_states[$];     // hand-typed next states of the directed table
    stim_row_t  stim_table[$];
    life_word_t got_word;
    life_word_t want_word;

    // grid model: register file, latched generation setup, three row buffers
    logic [WIDTH_W-1:0]  reg_width  = RESET_GRID_WIDTH;
    logic [HEIGHT_W-1:0] reg_height = RESET_GRID_HEIGHT;
    logic [RULE_W-1:0]   reg_lower  = RESET_BIRTH_LOWER;
    logic [RULE_W-1:0]   reg_upper  = RESET_UPPER_LIMIT;
    int gen_w  = 32;
    int gen_h  = 20;
    int gen_lo = 0;
    int gen_up = 8;
    bit cell_mem [0:2][0:MAX_COLS-1];
    int row_pos     = 0;
    int col_pos     = 0;
    bit seen_change = 1'b0;

    threshold_life_generation_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cell_alive     (cell_alive),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .row_index      (row_index),
        .col_index      (col_index),
        .next_alive     (next_alive),
        .cell_changed   (cell_changed),
        .any_changed    (any_changed),
        .generation_done(generation_done)
    );

    always #6 clk = ~clk;

    function automatic int clamp_dim(input int v, input int hi);
        return (v < MIN_DIM) ? MIN_DIM : ((v > hi) ? hi : v);
    endfunction

    // cells outside the grid are dead, no wrap
    function automatic bit grid_cell(input int r, input int c);
        if (r < 0 || c < 0 || r >= gen_h || c >= gen_w)
        begin
            return 1'b0;
        end
        return cell_mem[r % 3][c];
    endfunction

    // next state of one cell from its eight neighbors
    function automatic void rate_cell(input int r, input int c, input bit last);
        int         cnt;
        bit         cur;
        life_word_t w;
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                if (dr != 0 || dc != 0)
                begin
                    cnt += grid_cell(r + dr, c + dc);
                end
            end
        end
        cur = grid_cell(r, c);
        if (cur)
        begin
            w.nxt = (cnt < gen_up);
        end
        else
        begin
            w.nxt = (gen_lo < cnt) && (cnt < gen_up);
        end
        w.chg = w.nxt ^ cur;
        if (w.chg)
        begin
            seen_change = 1'b1;
        end
        w.row  = ROW_W'(r);
        w.col  = COL_W'(c);
        w.seen = seen_change;
        w.last = last;
        step_states.push_back(w);
    endfunction

    // take one raster cell, leave the words it frees in step_states
    function automatic void advance_generation(input logic alive);
        int r;
        int c;
        bit last_row;
        bit last_cell;
        step_states.delete();
        // setup is sampled at the first cell of a generation
        if (row_pos == 0 && col_pos == 0)
        begin
            gen_w  = clamp_dim(int'(reg_width), MAX_COLS);
            gen_h  = clamp_dim(int'(reg_height), MAX_ROWS);
            gen_lo = int'(reg_lower);
            gen_up = int'(reg_upper);
        end
        r = row_pos;
        c = col_pos;
        last_row  = (r == gen_h - 1);
        last_cell = last_row && (c == gen_w - 1);
        // last cell of the row two above goes out before its buffer is reused
        if (c == 0 && r >= 2)
        begin
            rate_cell(r - 2, gen_w - 1, 1'b0);
        end
        cell_mem[r % 3][c] = alive;
        if (c >= 1 && r >= 1)
        begin
            rate_cell(r - 1, c - 1, 1'b0);
        end
        if (last_row && c >= 1)
        begin
            rate_cell(r, c - 1, 1'b0);
        end
        // final cell flushes the right column of the last two rows
        if (last_cell)
        begin
            rate_cell(r - 1, c, 1'b0);
            rate_cell(r, c, 1'b1);
            row_pos     = 0;
            col_pos     = 0;
            seen_change = 1'b0;
        end
        else if (c + 1 >= gen_w)
        begin
            col_pos = 0;
            row_pos = r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endfunction

    function automatic life_word_t life_word(input int r, input int c, input bit nx,
                                             input bit ch, input bit sn, input bit dn);
        life_word_t w;
        w.row  = ROW_W'(r);
        w.col  = COL_W'(c);
        w.nxt  = nx;
        w.chg  = ch;
        w.seen = sn;
        w.last = dn;
        return w;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input int unsigned value);
        stim_row_t s;
        s.is_cfg      = 1'b1;
        s.reg_index   = idx;
        s.reg_value   = CFG_DATA_W'(value);
        s.alive       = 1'b0;
        s.typed_count = '0;
        return s;
    endfunction

    function automatic stim_row_t cell_row(input logic alive, input int typed);
        stim_row_t s;
        s.is_cfg      = 1'b0;
        s.reg_index   = '0;
        s.reg_value   = '0;
        s.alive       = alive;
        s.typed_count = 3'(typed);
        return s;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // send one cell word; expectations come from the model or the typed list
    task automatic drive_cell(input logic alive, input int typed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cell_alive <= alive;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        advance_generation(alive);
        if (typed == 0)
        begin
            foreach (step_states[i])
            begin
                pending_states.push_back(step_states[i]);
            end
        end
        else
        begin
            repeat (typed)
            begin
                pending_states.push_back(typed_states.pop_front());
            end
        end
        cells_sent++;
    endtask

    // register write once the core has drained
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        in_valid <= 1'b0;
        while (pending_states.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  reg_width  = WIDTH_W'(value);
            REG_GRID_HEIGHT: reg_height = HEIGHT_W'(value);
            REG_BIRTH_LOWER: reg_lower  = RULE_W'(value);
            REG_UPPER_LIMIT: reg_upper  = RULE_W'(value);
            default: ;
        endcase
    endtask

    // output side: random stall, long hold on request, check accepted words
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            got_word = {row_index, col_index, next_alive, cell_changed,
                        any_changed, generation_done};
            if (pending_states.size() == 0)
            begin
                note_mismatch($sformatf("unexpected word for cell (%0d,%0d)",
                                        got_word.row, got_word.col));
            end
            else
            begin
                want_word = pending_states.pop_front();
                words_checked++;
                if (want_word.last)
                begin
                    gens_checked++;
                end
                if (got_word.row != want_word.row)
                    note_mismatch($sformatf("row_index got %0d want %0d",
                                            got_word.row, want_word.row));
                if (got_word.col != want_word.col)
                    note_mismatch($sformatf("col_index got %0d want %0d",
                                            got_word.col, want_word.col));
                if (got_word.nxt != want_word.nxt)
                    note_mismatch($sformatf("next_alive got %0b want %0b at (%0d,%0d)",
                                            got_word.nxt, want_word.nxt,
                                            want_word.row, want_word.col));
                if (got_word.chg != want_word.chg)
                    note_mismatch($sformatf("cell_changed got %0b want %0b at (%0d,%0d)",
                                            got_word.chg, want_word.chg,
                                            want_word.row, want_word.col));
                if (got_word.seen != want_word.seen)
                    note_mismatch($sformatf("any_changed got %0b want %0b at (%0d,%0d)",
                                            got_word.seen, want_word.seen,
                                            want_word.row, want_word.col));
                if (got_word.last != want_word.last)
                    note_mismatch($sformatf("generation_done got %0b want %0b at (%0d,%0d)",
                                            got_word.last, want_word.last,
                                            want_word.row, want_word.col));
            end
        end
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("threshold_life_generation_core: mismatch");
        $finish;
    end

    // main stimulus
    initial
    begin
        int mode;
        int mode_cells;
        int n_cells;
        int density;
        int lo;

        // directed table: small grids, extremes, odd register values
        stim_table.push_back(cfg_row(REG_GRID_WIDTH, 2));
        stim_table.push_back(cfg_row(REG_GRID_HEIGHT, 2));
        // all dead under reset rules: nothing moves
        repeat (3) stim_table.push_back(cell_row(1'b0, 0));
        stim_table.push_back(cell_row(1'b0, 4));
        typed_states.push_back(life_word(0, 0, 0, 0, 0, 0));
        typed_states.push_back(life_word(1, 0, 0, 0, 0, 0));
        typed_states.push_back(life_word(0, 1, 0, 0, 0, 0));
        typed_states.push_back(life_word(1, 1, 0, 0, 0, 1));
        // all alive, three neighbors each, upper 8: all survive
        repeat (3) stim_table.push_back(cell_row(1'b1, 0));
        stim_table.push_back(cell_row(1'b1, 4));
        typed_states.push_back(life_word(0, 0, 1, 0, 0, 0));
        typed_states.push_back(life_word(1, 0, 1, 0, 0, 0));
        typed_states.push_back(life_word(0, 1, 1, 0, 0, 0));
        typed_states.push_back(life_word(1, 1, 1, 0, 0, 1));
        // upper 3: every cell dies
        stim_table.push_back(cfg_row(REG_UPPER_LIMIT, 3));
        repeat (3) stim_table.push_back(cell_row(1'b1, 0));
        stim_table.push_back(cell_row(1'b1, 4));
        typed_states.push_back(life_word(0, 0, 0, 1, 1, 0));
        typed_states.push_back(life_word(1, 0, 0, 1, 1, 0));
        typed_states.push_back(life_word(0, 1, 0, 1, 1, 0));
        typed_states.push_back(life_word(1, 1, 0, 1, 1, 1));
        // geometry below minimum, rules at 15, unused index: grid is frozen
        stim_table.push_back(cfg_row(REG_GRID_WIDTH, 0));
        stim_table.push_back(cfg_row(REG_GRID_HEIGHT, 1));
        stim_table.push_back(cfg_row(REG_BIRTH_LOWER, 15));
        stim_table.push_back(cfg_row(REG_UPPER_LIMIT, 15));
        stim_table.push_back(cfg_row(UNUSED_REG_INDEX, 2047));
        stim_table.push_back(cell_row(1'b1, 0));
        stim_table.push_back(cell_row(1'b0, 0));
        stim_table.push_back(cell_row(1'b0, 0));
        stim_table.push_back(cell_row(1'b1, 4));
        typed_states.push_back(life_word(0, 0, 1, 0, 0, 0));
        typed_states.push_back(life_word(1, 0, 0, 0, 0, 0));
        typed_states.push_back(life_word(0, 1, 0, 0, 0, 0));
        typed_states.push_back(life_word(1, 1, 1, 0, 0, 1));
        // 3x2 grid with a rule write halfway: applies only to the next grid
        stim_table.push_back(cfg_row(REG_GRID_WIDTH, 3));
        stim_table.push_back(cfg_row(REG_GRID_HEIGHT, 2));
        stim_table.push_back(cfg_row(REG_BIRTH_LOWER, 1));
        stim_table.push_back(cfg_row(REG_UPPER_LIMIT, 4));
        stim_table.push_back(cell_row(1'b1, 0));
        stim_table.push_back(cell_row(1'b1, 0));
        stim_table.push_back(cell_row(1'b0, 0));
        stim_table.push_back(cfg_row(REG_BIRTH_LOWER, 8));
        stim_table.push_back(cell_row(1'b0, 0));
        stim_table.push_back(cell_row(1'b1, 0));
        stim_table.push_back(cell_row(1'b1, 0));

        // reset
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].is_cfg)
            begin
                write_reg(stim_table[i].reg_index, stim_table[i].reg_value);
            end
            else
            begin
                drive_cell(stim_table[i].alive, int'(stim_table[i].typed_count));
            end
        end

        // random grids under three idling mixes
        for (mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 25 : ((mode == 1) ? 80 : 0);
            recv_idle_pct = (mode == 0) ? 80 : ((mode == 1) ? 25 : 0);
            mode_cells = 0;
            while (mode_cells < MODE_CELLS)
            begin
                // sometimes run grids back to back with the same setup
                if (mode_cells == 0 || $urandom_range(1) == 1)
                begin
                    write_reg(REG_GRID_WIDTH, $urandom_range(4));
                    write_reg(REG_GRID_HEIGHT, $urandom_range(3));
                    lo = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(3);
                    write_reg(REG_BIRTH_LOWER, lo);
                    write_reg(REG_UPPER_LIMIT,
                              ($urandom_range(4) == 0) ? $urandom_range(15)
                                                       : $urandom_range(2, 9));
                end
                density = $urandom_range(10, 90);
                n_cells = clamp_dim(int'(reg_width), MAX_COLS) *
                          clamp_dim(int'(reg_height), MAX_ROWS);
                repeat (n_cells) drive_cell($urandom_range(99) < density, 0);
                mode_cells += n_cells;
            end
        end

        // widest grid, output held off long enough to back up the input
        write_reg(REG_GRID_WIDTH, 63);
        write_reg(REG_GRID_HEIGHT, 2);
        write_reg(REG_BIRTH_LOWER, 2);
        write_reg(REG_UPPER_LIMIT, 4);
        hold_requests++;
        repeat (64) drive_cell($urandom_range(1) == 1, 0);

        // dense grid: eight-neighbor counts with upper above 8
        write_reg(REG_GRID_WIDTH, 3);
        write_reg(REG_GRID_HEIGHT, 3);
        write_reg(REG_BIRTH_LOWER, 7);
        write_reg(REG_UPPER_LIMIT, 9);
        repeat (9) drive_cell($urandom_range(99) < 90, 0);

        // drain and watch for stray words
        in_valid <= 1'b0;
        while (pending_states.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d cells; checked %0d next-state words over %0d generations.",
                 cells_sent, words_checked, gens_checked);
        $display("Grids from 2x2 to 32x2, rules up to 15, mid-grid write, long hold.");
        if (error_count == 0)
        begin
            $display("threshold_life_generation_core: match");
        end
        else
        begin
            $display("threshold_life_generation_core: mismatch");
        end
        $finish;
    end

endmodule
